/* src/lcrw_pkg.sv */
// lcrw_pkg: shared constants for the rectangular window line clipper
// no dependencies; used by lcrw_edge, line_clip_rect_window_top and the testbench
package lcrw_pkg;

   // clip edges, in processing order
   localparam int EDGE_LEFT   = 0;
   localparam int EDGE_RIGHT  = 1;
   localparam int EDGE_BOTTOM = 2;
   localparam int EDGE_TOP    = 3;
   localparam int NUM_EDGES   = 4;

   // window register indexes on the csr port
   typedef enum logic [1:0] {
      REG_LEFT   = 2'd0,
      REG_RIGHT  = 2'd1,
      REG_BOTTOM = 2'd2,
      REG_TOP    = 2'd3
   } reg_idx_type;

   localparam int RESET_LOW  = 100;
   localparam int RESET_HIGH = 500;

endpackage

/* src/lcrw_edge.sv */
// lcrw_edge: pipelined clip of one segment against one window edge
// outcode check, multiply, restoring divide one bit per stage, final add
// depends on lcrw_pkg
module lcrw_edge #(
   parameter int W    = 16,
   parameter int EDGE = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic             in_rej,
   input  logic [4*W-1:0]   in_pts,   // start x, start y, end x, end y
   input  logic [W-1:0]     bound,
   output logic             out_valid,
   output logic             out_rej,
   output logic [4*W-1:0]   out_pts
);

   localparam int AX    = (EDGE == lcrw_pkg::EDGE_LEFT || EDGE == lcrw_pkg::EDGE_RIGHT) ? 0 : 1;
   localparam int OT    = 1 - AX;
   localparam int CW    = W + 1;
   localparam int PW    = 2 * CW;
   localparam bit LOWER = (EDGE == lcrw_pkg::EDGE_LEFT || EDGE == lcrw_pkg::EDGE_BOTTOM);

   typedef struct packed {
      logic           valid;
      logic           rej;
      logic           move;
      logic           mv;
      logic           neg;
      logic [4*W-1:0] pts;
      logic [CW-1:0]  dm;
      logic [CW-1:0]  nm;
      logic [CW-1:0]  denm;
   } a_type;

   typedef struct packed {
      logic           valid;
      logic           rej;
      logic           move;
      logic           mv;
      logic           neg;
      logic [4*W-1:0] pts;
      logic [PW-1:0]  prod;
      logic [CW-1:0]  denm;
   } b_type;

   typedef struct packed {
      logic           valid;
      logic           rej;
      logic           move;
      logic           mv;
      logic           neg;
      logic [4*W-1:0] pts;
      logic [CW-1:0]  rem;
      logic [CW-1:0]  low;
      logic [CW-1:0]  q;
      logic [CW-1:0]  denm;
   } d_type;

   // stage a: outcodes and operand magnitudes
   logic signed [W-1:0]  s_a, s_o, e_a, e_o, bnd;
   logic signed [CW-1:0] den, num, dif;
   logic                 ob, oe;
   a_type                a_in, a_ff;

   always_comb begin
      s_a = $signed(in_pts[AX*W +: W]);
      s_o = $signed(in_pts[OT*W +: W]);
      e_a = $signed(in_pts[(2+AX)*W +: W]);
      e_o = $signed(in_pts[(2+OT)*W +: W]);
      bnd = $signed(bound);
      ob  = LOWER ? (s_a < bnd) : (s_a > bnd);
      oe  = LOWER ? (e_a < bnd) : (e_a > bnd);
      den = CW'(e_a) - CW'(s_a);
      num = CW'(bnd) - CW'(s_a);
      dif = CW'(e_o) - CW'(s_o);
      a_in.valid = in_valid;
      a_in.rej   = in_rej | (ob & oe);
      a_in.move  = ~in_rej & (ob ^ oe);
      a_in.mv    = ~ob;
      a_in.neg   = dif[CW-1] ^ num[CW-1] ^ den[CW-1];
      a_in.pts   = in_pts;
      a_in.dm    = dif[CW-1] ? CW'(-dif) : CW'(dif);
      a_in.nm    = num[CW-1] ? CW'(-num) : CW'(num);
      a_in.denm  = den[CW-1] ? CW'(-den) : CW'(den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
      end else if (en) begin
         a_ff <= a_in;
      end
   end

   // stage b: product of magnitudes
   b_type b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff <= '0;
      end else if (en) begin
         b_ff.valid <= a_ff.valid;
         b_ff.rej   <= a_ff.rej;
         b_ff.move  <= a_ff.move;
         b_ff.mv    <= a_ff.mv;
         b_ff.neg   <= a_ff.neg;
         b_ff.pts   <= a_ff.pts;
         b_ff.prod  <= PW'(a_ff.dm) * PW'(a_ff.nm);
         b_ff.denm  <= a_ff.denm;
      end
   end

   // divider: one quotient bit per stage, msb first
   d_type div_ff [0:CW];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff[0] <= '0;
      end else if (en) begin
         div_ff[0].valid <= b_ff.valid;
         div_ff[0].rej   <= b_ff.rej;
         div_ff[0].move  <= b_ff.move;
         div_ff[0].mv    <= b_ff.mv;
         div_ff[0].neg   <= b_ff.neg;
         div_ff[0].pts   <= b_ff.pts;
         div_ff[0].rem   <= b_ff.prod[PW-1:CW];
         div_ff[0].low   <= b_ff.prod[CW-1:0];
         div_ff[0].q     <= '0;
         div_ff[0].denm  <= b_ff.denm;
      end
   end

   for (genvar i = 0; i < CW; i++) begin : g_div
      logic [CW:0] trial;
      logic        ge;
      d_type       step_in;

      always_comb begin
         trial         = {div_ff[i].rem, div_ff[i].low[CW-1]};
         ge            = trial >= {1'b0, div_ff[i].denm};
         step_in       = div_ff[i];
         step_in.rem   = ge ? CW'(trial - {1'b0, div_ff[i].denm}) : CW'(trial);
         step_in.low   = {div_ff[i].low[CW-2:0], 1'b0};
         step_in.q     = {div_ff[i].q[CW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[i+1] <= '0;
         end else if (en) begin
            div_ff[i+1] <= step_in;
         end
      end
   end

   // final stage: apply the signed quotient and move the outside point
   d_type          fin;
   logic [CW-1:0]  base, sum;
   logic [4*W-1:0] pts_in;
   logic           valid_ff, rej_ff;
   logic [4*W-1:0] pts_ff;

   always_comb begin
      fin    = div_ff[CW];
      base   = CW'($signed(fin.pts[OT*W +: W]));
      sum    = fin.neg ? base - fin.q : base + fin.q;
      pts_in = fin.pts;
      if (fin.move && fin.denm != '0) begin
         pts_in[(2*fin.mv+AX)*W +: W] = bound;
         pts_in[(2*fin.mv+OT)*W +: W] = sum[W-1:0];
      end else if (fin.move) begin
         pts_in[(2*fin.mv+AX)*W +: W] = bound;
         pts_in[(2*fin.mv+OT)*W +: W] = base[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rej_ff   <= 1'b0;
      end else if (en) begin
         valid_ff <= fin.valid;
         rej_ff   <= fin.rej;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pts_ff <= pts_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rej   = rej_ff;
   assign out_pts   = pts_ff;

endmodule

/* src/line_clip_rect_window_top.sv */
// line_clip_rect_window_top: segment clipper against a register-held window
// each request passes through the left, right, bottom and top edge pipelines, each with a multiplier and a
// one-bit-per-stage divider, and then through the output register
// throughput: one request per cycle; all stages stall while a held result waits on rsp_tready
// reset: synchronous, clears all valid bits and loads the window 100/500/100/500
// depends on lcrw_pkg and lcrw_edge
module line_clip_rect_window_top #(
   parameter int COORD_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [(4*COORD_BITS+7)/8*8-1:0] req_tdata,   // start_x, start_y, end_x, end_y,
                                                        // zero pad
   // result channel
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [(4*COORD_BITS+7)/8*8-1:0] rsp_tdata,   // clip_start_x, clip_start_y,
                                                        // clip_end_x, clip_end_y, zero pad
   output logic                    rsp_tuser,   // visible
   // window registers
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [3:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   localparam int W       = COORD_BITS;
   localparam int IN_BITS = (4 * COORD_BITS + 7) / 8 * 8;

   // window registers; the user must write them only while the pipeline is empty (not enforced)
   logic [W-1:0] win_ff [lcrw_pkg::NUM_EDGES];
   logic         wr_en;
   lcrw_pkg::reg_idx_type wr_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign wr_idx     = lcrw_pkg::reg_idx_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff[lcrw_pkg::REG_LEFT]   <= W'(lcrw_pkg::RESET_LOW);
         win_ff[lcrw_pkg::REG_RIGHT]  <= W'(lcrw_pkg::RESET_HIGH);
         win_ff[lcrw_pkg::REG_BOTTOM] <= W'(lcrw_pkg::RESET_LOW);
         win_ff[lcrw_pkg::REG_TOP]    <= W'(lcrw_pkg::RESET_HIGH);
      end else if (wr_en) begin
         win_ff[wr_idx] <= csr_pwdata[W-1:0];
      end
   end

   // read back sign-extended
   assign csr_prdata = 32'($signed(win_ff[wr_idx]));

   // global pipeline advance: move whenever the output register is free or taken
   logic en;
   logic out_valid_ff;

   assign en         = ~out_valid_ff | rsp_tready;
   assign req_tready = en;

   // chain of edge pipelines: left, right, bottom, top
   logic           stg_valid [lcrw_pkg::NUM_EDGES+1];
   logic           stg_rej   [lcrw_pkg::NUM_EDGES+1];
   logic [4*W-1:0] stg_pts   [lcrw_pkg::NUM_EDGES+1];

   assign stg_valid[0] = req_tvalid;
   assign stg_rej[0]   = 1'b0;
   assign stg_pts[0]   = req_tdata[4*W-1:0];

   for (genvar e = 0; e < lcrw_pkg::NUM_EDGES; e++) begin : g_edge
      lcrw_edge #(
         .W    (W),
         .EDGE (e)
      ) u_edge (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (stg_valid[e]),
         .in_rej    (stg_rej[e]),
         .in_pts    (stg_pts[e]),
         .bound     (win_ff[e]),
         .out_valid (stg_valid[e+1]),
         .out_rej   (stg_rej[e+1]),
         .out_pts   (stg_pts[e+1])
      );
   end

   // output register; rejected segments report zero coordinates
   logic           out_vis_ff;
   logic [4*W-1:0] out_pts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= stg_valid[lcrw_pkg::NUM_EDGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_vis_ff <= ~stg_rej[lcrw_pkg::NUM_EDGES];
         out_pts_ff <= stg_rej[lcrw_pkg::NUM_EDGES] ? '0 : stg_pts[lcrw_pkg::NUM_EDGES];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_vis_ff;
   assign rsp_tdata  = IN_BITS'(out_pts_ff);

endmodule

/* tb/line_clip_rect_window_top_tb.sv */
// line_clip_rect_window_top_tb: self-checking bench for the window line clipper
// drives segments on the request stream, predicts each clipped result, checks rsp stream
// depends on lcrw_pkg and line_clip_rect_window_top
module line_clip_rect_window_top_tb;

   localparam int CB = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic        visible;
      logic [15:0] sx, sy, ex, ey;
   } clip_result_type;

   typedef struct {
      logic [15:0] sx, sy, ex, ey;
      logic        has_exp;
      clip_result_type exp;
   } seg_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   line_clip_rect_window_top #(.COORD_BITS(CB)) uut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // window copy held by the predictor
   logic signed [15:0] win [lcrw_pkg::NUM_EDGES];
   clip_result_type expected_clips [$];
   int errors = 0;
   int sent = 0, received = 0, rejected = 0;
   int idle_cycles = 0;
   bit hold_off = 0;
   bit random_stall = 1;

   function automatic longint lerp_coord(longint a0, longint a1, longint b0, longint b1,
                                         longint edge_pos);
      longint den, num, d, q;
      den = a1 - a0;
      num = edge_pos - a0;
      d = b1 - b0;
      if (den == 0) return b0;
      // division of longint truncates toward zero
      q = (d * num) / den;
      return b0 + q;
   endfunction

   function automatic clip_result_type clip_segment(logic [15:0] sx, logic [15:0] sy,
                                                    logic [15:0] ex, logic [15:0] ey);
      longint p [2][2];
      longint b, v;
      bit ob, oe;
      int ax, ot, mv;
      clip_result_type r;
      p[0][0] = $signed(sx); p[0][1] = $signed(sy);
      p[1][0] = $signed(ex); p[1][1] = $signed(ey);
      for (int e = 0; e < lcrw_pkg::NUM_EDGES; e++) begin
         ax = (e < 2) ? 0 : 1;
         ot = 1 - ax;
         b = win[e];
         if (e == lcrw_pkg::EDGE_LEFT || e == lcrw_pkg::EDGE_BOTTOM) begin
            ob = p[0][ax] < b; oe = p[1][ax] < b;
         end else begin
            ob = p[0][ax] > b; oe = p[1][ax] > b;
         end
         if (ob && oe) return '0;
         if (ob != oe) begin
            mv = ob ? 0 : 1;
            v = lerp_coord(p[0][ax], p[1][ax], p[0][ot], p[1][ot], b);
            p[mv][ax] = b;
            p[mv][ot] = v;
         end
      end
      r.visible = 1;
      r.sx = p[0][0][15:0]; r.sy = p[0][1][15:0];
      r.ex = p[1][0][15:0]; r.ey = p[1][1][15:0];
      return r;
   endfunction

   // result checker and receiver stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         clip_result_type got, want;
         got = {rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32],
                rsp_tdata[63:48]};
         received <= received + 1;
         if (!rsp_tuser) rejected <= rejected + 1;
         if (expected_clips.size() == 0) begin
            $error("unexpected result visible=%0d", rsp_tuser);
            errors++;
         end else begin
            want = expected_clips.pop_front();
            if (got.visible !== want.visible) begin
               $error("visible exp %0d got %0d", want.visible, got.visible); errors++;
            end
            if (got.sx !== want.sx) begin
               $error("clip_start_x exp %0d got %0d", $signed(want.sx), $signed(got.sx));
               errors++;
            end
            if (got.sy !== want.sy) begin
               $error("clip_start_y exp %0d got %0d", $signed(want.sy), $signed(got.sy));
               errors++;
            end
            if (got.ex !== want.ex) begin
               $error("clip_end_x exp %0d got %0d", $signed(want.ex), $signed(got.ex));
               errors++;
            end
            if (got.ey !== want.ey) begin
               $error("clip_end_y exp %0d got %0d", $signed(want.ey), $signed(got.ey));
               errors++;
            end
         end
      end
      // receiver: own stall pattern, long hold-off on request, free-run stretches
      if (hold_off) rsp_tready <= 0;
      else if (!random_stall) rsp_tready <= 1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // watchdog on cycles with no accepted traffic
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // apb write of one window register, only while the block is idle
   task automatic write_window(lcrw_pkg::reg_idx_type idx, logic signed [15:0] value);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= {{16{value[15]}}, value};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      win[idx] = value;
   endtask

   task automatic set_window(logic signed [15:0] l, logic signed [15:0] r,
                             logic signed [15:0] b, logic signed [15:0] t);
      write_window(lcrw_pkg::REG_LEFT, l);
      write_window(lcrw_pkg::REG_RIGHT, r);
      write_window(lcrw_pkg::REG_BOTTOM, b);
      write_window(lcrw_pkg::REG_TOP, t);
   endtask

   // offer one segment, hold until accepted, queue its predicted clip
   task automatic send_segment(logic [15:0] sx, logic [15:0] sy, logic [15:0] ex,
                               logic [15:0] ey);
      req_tvalid <= 1;
      req_tdata <= {ey, ex, sy, sx};
      expected_clips.push_back(clip_segment(sx, sy, ex, ey));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic pause_sender();
      req_tvalid <= 0;
      @(posedge clock);
   endtask

   // all results in, then the pipeline latency before touching registers
   task automatic drain();
      pause_sender();
      while (expected_clips.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_coord(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 700));
         default: return 16'($signed(16'($urandom_range(0, 200))) - 16'sd100);
      endcase
   endfunction

   seg_row_type directed [$];

   task automatic add_row(int sx, int sy, int ex, int ey);
      seg_row_type r;
      r.sx = 16'(sx); r.sy = 16'(sy); r.ex = 16'(ex); r.ey = 16'(ey);
      r.has_exp = 0; r.exp = '0;
      directed.push_back(r);
   endtask

   task automatic add_row_exp(int sx, int sy, int ex, int ey, clip_result_type e);
      seg_row_type r;
      r.sx = 16'(sx); r.sy = 16'(sy); r.ex = 16'(ex); r.ey = 16'(ey);
      r.has_exp = 1; r.exp = e;
      directed.push_back(r);
   endtask

   initial begin
      int burst, mode;
      bit did_hold, did_wait;
      clip_result_type pred;
      win[lcrw_pkg::EDGE_LEFT] = 16'(lcrw_pkg::RESET_LOW);
      win[lcrw_pkg::EDGE_RIGHT] = 16'(lcrw_pkg::RESET_HIGH);
      win[lcrw_pkg::EDGE_BOTTOM] = 16'(lcrw_pkg::RESET_LOW);
      win[lcrw_pkg::EDGE_TOP] = 16'(lcrw_pkg::RESET_HIGH);
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed table against the reset window 100..500
      add_row_exp(200, 200, 300, 300, {1'b1, 16'd200, 16'd200, 16'd300, 16'd300});
      add_row_exp(100, 100, 500, 500, {1'b1, 16'd100, 16'd100, 16'd500, 16'd500});
      add_row_exp(0, 200, 50, 300, '0);       // both left
      add_row_exp(600, 200, 700, 300, '0);    // both right
      add_row_exp(200, 0, 300, 50, '0);       // both below
      add_row_exp(200, 600, 300, 900, '0);    // both above
      add_row_exp(0, 300, 600, 300, {1'b1, 16'd100, 16'd300, 16'd500, 16'd300});
      add_row_exp(300, 0, 300, 600, {1'b1, 16'd300, 16'd100, 16'd300, 16'd500});
      add_row_exp(-32768, -32768, -32768, -32768, '0);
      add_row_exp(32767, 32767, 32767, 32767, '0);
      add_row(-32768, -32768, 32767, 32767);  // diagonal through window
      add_row(32767, -32768, -32768, 32767);
      add_row(0, 0, 600, 200);                // clipped on left, right and bottom edges
      add_row(50, 600, 300, 0);
      add_row(-1, 250, 700, 251);             // truncation toward zero
      add_row(700, 251, -1, 250);
      add_row(0, 450, 450, 600);
      add_row(-21846, 21845, 21845, -21846);  // alternating bit patterns
      foreach (directed[i]) begin
         if (directed[i].has_exp) begin
            pred = clip_segment(directed[i].sx, directed[i].sy, directed[i].ex, directed[i].ey);
            if (pred !== directed[i].exp) begin
               $error("directed row %0d table disagrees with prediction", i); errors++;
            end
         end
         send_segment(directed[i].sx, directed[i].sy, directed[i].ex, directed[i].ey);
      end
      drain();

      // window settings, extremes included; inverted window exercises no-special-case path
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_window(-32768, 32767, -32768, 32767);
            1: set_window(0, 0, 0, 0);
            2: set_window(32767, -32768, 32767, -32768);
            3: set_window(-100, 100, -100, 100);
            4: set_window(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            default: set_window(-20, 300, 50, 600);
         endcase
         did_hold = 0;
         did_wait = 0;
         for (int n = 0; n < 150; ) begin
            burst = $urandom_range(1, 30);
            random_stall = (phase != 3);
            for (int k = 0; k < burst && n < 150; k++, n++) begin
               mode = (phase == 3 || phase == 1) ? 2 : (phase == 5 ? 1 : $urandom_range(0, 2));
               send_segment(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                            rand_coord(mode));
            end
            if (n >= 60 && !did_hold) begin
               // long receiver hold-off while the sender keeps offering
               did_hold = 1;
               hold_off = 1;
               fork
                  begin
                     repeat (300) @(posedge clock);
                     hold_off = 0;
                  end
               join_none
            end
            if (n >= 100 && !did_wait) begin
               // sender waits for every outstanding result
               did_wait = 1;
               pause_sender();
               while (expected_clips.size() != 0) @(posedge clock);
            end else if ($urandom_range(0, 1)) begin
               pause_sender();
               repeat ($urandom_range(0, 8)) @(posedge clock);
            end
         end
         drain();
      end

      $display("covered %0d segments (%0d results, %0d rejected) over 7 window settings",
               sent, received, rejected);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

/* files.f */
src/lcrw_pkg.sv
src/lcrw_edge.sv
src/line_clip_rect_window_top.sv
tb/line_clip_rect_window_top_tb.sv
